// ===== design/sem_pkg.sv =====
// Shared types, constants and gradient functions of the Sobel edge magnitude core.
`default_nettype none
package sem_pkg;

	localparam int MAX_W    = 2048;
	localparam int ADDR_W   = $clog2(MAX_W);
	localparam int PIX_W    = 16;
	localparam int WREG_W   = 12;
	localparam int HREG_W   = 16;
	localparam int PEND_W   = 12;
	localparam int GRAD_W   = 19;
	localparam int SQ_W     = 38;
	localparam int MAG_W    = 19;
	localparam int CIDX_W   = 2;
	localparam int CDATA_W  = 16;

	// Luminance weights, scaled by 65536; they sum to exactly 65536.
	localparam logic [15:0] LUM_R = 16'd13933;
	localparam logic [15:0] LUM_G = 16'd46871;
	localparam logic [15:0] LUM_B = 16'd4732;

	// Operation codes.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd1;

	typedef logic [PIX_W-1:0] pix_t;

	// One entry of the queue between front and back.
	typedef struct packed {
		logic op;
		pix_t lum;
	} qent_t;

	// Frame geometry handed to the back part.
	typedef struct packed {
		logic [WREG_W-1:0] width;
		logic [HREG_W-1:0] height;
		logic              restart;
	} geom_t;

	// Weighted column or row sum: a + 2*b + c.
	function automatic logic [PIX_W+1:0] wsum(pix_t a, pix_t b, pix_t c);
		return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
	endfunction

	// Signed difference of two weighted sums.
	function automatic logic signed [GRAD_W-1:0] wdiff(logic [PIX_W+1:0] p,
			logic [PIX_W+1:0] n);
		return signed'({1'b0, p}) - signed'({1'b0, n});
	endfunction

endpackage
`default_nettype wire

// ===== design/sem_front.sv =====
// Front part: takes items in and forms the luminance of each pixel over two stages.
`default_nettype none
module sem_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic                operation,
	input  wire logic [15:0]         red,
	input  wire logic [15:0]         green,
	input  wire logic [15:0]         blue,
	input  wire logic                q_full,
	output logic                     q_push,
	output sem_pkg::qent_t           q_data
);

	logic        valid_s1, valid_s2;
	logic        op_s1, op_s2;
	logic [31:0] pr_s1, pg_s1, pb_s1;
	logic [31:0] sum_s2;
	logic        adv;

	// The pipe moves whenever its last stage is empty or drains into the queue.
	assign adv    = !valid_s2 || !q_full;
	assign full   = !adv;
	assign q_push = valid_s2 && !q_full;
	// The weights sum to 65536, so the luminance always fits its 16 bits.
	assign q_data = '{op: op_s2, lum: sum_s2[31:16]};

	// Control of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= push;
			valid_s2 <= valid_s1;
		end
	end

	// Stage one multiplies, stage two adds.
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= operation;
			pr_s1  <= 32'(red) * 32'(sem_pkg::LUM_R);
			pg_s1  <= 32'(green) * 32'(sem_pkg::LUM_G);
			pb_s1  <= 32'(blue) * 32'(sem_pkg::LUM_B);
			op_s2  <= op_s1;
			sum_s2 <= pr_s1 + pg_s1 + pb_s1;
		end
	end

endmodule
`default_nettype wire

// ===== design/sem_queue.sv =====
// Four-entry queue that decouples the front part from the back part.
`default_nettype none
module sem_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire sem_pkg::qent_t wr_data,
	output logic                full,
	input  wire logic           rd_en,
	output sem_pkg::qent_t      rd_data,
	output logic                empty
);

	sem_pkg::qent_t mem_q [0:3];
	logic [1:0]     wr_ptr_q, rd_ptr_q;
	logic [2:0]     count_q;

	assign full    = count_q == 3'd4;
	assign empty   = count_q == 3'd0;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 2'd1;
			if (wr_en && !rd_en) count_q <= count_q + 3'd1;
			else if (rd_en && !wr_en) count_q <= count_q - 3'd1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

// ===== design/sem_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module sem_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [sem_pkg::SQ_W-1:0]    value,
	output logic                             busy,
	output logic                             done,
	output logic [sem_pkg::MAG_W-1:0]        root
);

	logic [sem_pkg::SQ_W-1:0]   val_q;
	logic [sem_pkg::MAG_W+1:0]  rem_q;
	logic [sem_pkg::MAG_W-1:0]  root_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q, done_q;
	logic [sem_pkg::MAG_W+3:0]  shifted, trial;
	logic                       take;

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

	// Bring down the next two bits and try to set the next root bit.
	assign shifted = {rem_q, val_q[sem_pkg::SQ_W-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign take    = shifted >= trial;

	// Sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'(sem_pkg::MAG_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[sem_pkg::SQ_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= (sem_pkg::MAG_W+2)'(shifted - trial);
				root_q <= {root_q[sem_pkg::MAG_W-2:0], 1'b1};
			end else begin
				rem_q  <= (sem_pkg::MAG_W+2)'(shifted);
				root_q <= {root_q[sem_pkg::MAG_W-2:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/sem_back.sv =====
// Back part: line stores, 3x3 window, Sobel gradients, square root and result register.
`default_nettype none
module sem_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sem_pkg::geom_t            geom,
	input  wire sem_pkg::qent_t            q_data,
	input  wire logic                      q_empty,
	output logic                           q_pop,
	input  wire logic                      pop,
	output logic                           empty,
	output logic [sem_pkg::MAG_W-1:0]      magnitude,
	output logic                           frame_end
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_WRITE  = 3'd2;
	localparam logic [2:0] ST_SQUARE = 3'd3;
	localparam logic [2:0] ST_SUM    = 3'd4;
	localparam logic [2:0] ST_ROOT   = 3'd5;

	localparam int AW = sem_pkg::ADDR_W;
	localparam int GW = sem_pkg::GRAD_W;

	logic [2:0]                   state_q;
	logic                         op_q, first_q, pre_q, fe_q;
	sem_pkg::pix_t                lum_q;
	logic [AW-1:0]                col_q;
	logic [sem_pkg::HREG_W-1:0]   row_q;
	logic [sem_pkg::PEND_W-1:0]   pend_q;
	sem_pkg::pix_t                win_q [0:8];
	sem_pkg::pix_t                up_rd_q, mid_rd_q;
	sem_pkg::pix_t                upper_mem [0:sem_pkg::MAX_W-1];
	sem_pkg::pix_t                middle_mem [0:sem_pkg::MAX_W-1];
	logic signed [GW-1:0]         pre_gx_q, pre_gy_q, gx_q, gy_q;
	logic [2*GW-2:0]              sqx_q, sqy_q;
	logic [sem_pkg::SQ_W-1:0]     sq_sum;
	logic                         out_valid_q, out_fe_q;
	logic [sem_pkg::MAG_W-1:0]    out_mag_q;

	logic [sem_pkg::WREG_W-1:0]   w_eff;
	logic [sem_pkg::HREG_W-1:0]   h_eff;
	logic                         row_done, accept, mem_we;
	sem_pkg::pix_t                top_v, mid_v, bot_v;
	sem_pkg::pix_t                pl_t, pl_m, pl_b, ql_t, ql_m, ql_b;
	logic signed [GW-1:0]         pre_gx, pre_gy, post_gx, post_gy;
	logic                         post, produced;
	logic [sem_pkg::WREG_W-1:0]   col_inc;
	logic [sem_pkg::PEND_W-1:0]   pend_dec;
	logic                         root_start, root_busy, root_done;
	logic [sem_pkg::MAG_W-1:0]    root_val;
	logic                         out_load;

	// Effective frame geometry.
	always_comb begin
		if (geom.width == '0) w_eff = sem_pkg::WREG_W'(1);
		else if (geom.width > sem_pkg::WREG_W'(sem_pkg::MAX_W))
			w_eff = sem_pkg::WREG_W'(sem_pkg::MAX_W);
		else w_eff = geom.width;
		h_eff = (geom.height == '0) ? sem_pkg::HREG_W'(1) : geom.height;
	end

	assign row_done = row_q >= h_eff;

	// An item starts work when it is a pixel inside the frame, or a drain past the frame's last row with results owed.
	assign q_pop  = (state_q == ST_IDLE) && !q_empty;
	assign accept = q_pop && ((q_data.op == sem_pkg::OP_PIXEL) ? !row_done
		: (row_done && pend_q != '0));

	// Gradients of the window before it shifts: a result owed for the previous row's end.
	always_comb begin
		pl_t = (w_eff >= sem_pkg::WREG_W'(2)) ? win_q[3] : win_q[6];
		pl_m = (w_eff >= sem_pkg::WREG_W'(2)) ? win_q[4] : win_q[7];
		pl_b = (w_eff >= sem_pkg::WREG_W'(2)) ? win_q[5] : win_q[8];
		pre_gx = sem_pkg::wdiff(sem_pkg::wsum(win_q[6], win_q[7], win_q[8]),
			sem_pkg::wsum(pl_t, pl_m, pl_b));
		pre_gy = sem_pkg::wdiff(sem_pkg::wsum(pl_t, win_q[6], win_q[6]),
			sem_pkg::wsum(pl_b, win_q[8], win_q[8]));
	end

	// New column entering the window; rows clamp at the frame's top and bottom.
	always_comb begin
		mid_v = mid_rd_q;
		top_v = (row_q == sem_pkg::HREG_W'(1)) ? mid_rd_q : up_rd_q;
		bot_v = (op_q == sem_pkg::OP_DRAIN) ? mid_rd_q : lum_q;
	end

	// Gradients of the shifted window, centered on the previous column.
	always_comb begin
		ql_t = (col_q == AW'(1)) ? win_q[6] : win_q[3];
		ql_m = (col_q == AW'(1)) ? win_q[7] : win_q[4];
		ql_b = (col_q == AW'(1)) ? win_q[8] : win_q[5];
		post_gx = sem_pkg::wdiff(sem_pkg::wsum(top_v, mid_v, bot_v),
			sem_pkg::wsum(ql_t, ql_m, ql_b));
		post_gy = sem_pkg::wdiff(sem_pkg::wsum(ql_t, win_q[6], top_v),
			sem_pkg::wsum(ql_b, win_q[8], bot_v));
		post     = (col_q != '0) && (row_q != '0);
		produced = post || pre_q;
		col_inc  = {1'b0, col_q} + sem_pkg::WREG_W'(1);
		pend_dec = pend_q - sem_pkg::PEND_W'(1);
	end

	// Sum of the squared gradients, taken by the square root as it starts.
	assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

	assign mem_we     = state_q == ST_WRITE;
	assign root_start = state_q == ST_SUM;
	assign out_load   = (state_q == ST_ROOT) && root_done && (!out_valid_q || pop);

	// Sequencer and frame position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			pend_q  <= '0;
			first_q <= 1'b0;
			pre_q   <= 1'b0;
			fe_q    <= 1'b0;
		end else if (geom.restart) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			pend_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
						first_q <= 1'b1;
					end
				end
				ST_READ: begin
					pre_q   <= (col_q == '0) && (row_q >= sem_pkg::HREG_W'(2));
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (col_inc >= w_eff) begin
						col_q <= '0;
						if (row_q != '1) row_q <= row_q + sem_pkg::HREG_W'(1);
					end else begin
						col_q <= col_inc[AW-1:0];
					end
					fe_q <= 1'b0;
					if (produced) begin
						state_q <= ST_SQUARE;
						if (op_q == sem_pkg::OP_DRAIN) begin
							pend_q <= pend_dec;
							// The frame's last result restarts the position.
							if (pend_dec == '0) begin
								fe_q  <= 1'b1;
								col_q <= '0;
								row_q <= '0;
							end
						end
					end else if (op_q == sem_pkg::OP_DRAIN) begin
						first_q <= 1'b0;
						state_q <= first_q ? ST_READ : ST_IDLE;
					end else begin
						pend_q  <= pend_q + sem_pkg::PEND_W'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_SQUARE: state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_ROOT;
				ST_ROOT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload and gradient datapath.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q  <= q_data.op;
			lum_q <= q_data.lum;
		end
		if (state_q == ST_READ) begin
			pre_gx_q <= pre_gx;
			pre_gy_q <= pre_gy;
		end
		if (state_q == ST_WRITE) begin
			gx_q <= post ? post_gx : pre_gx_q;
			gy_q <= post ? post_gy : pre_gy_q;
		end
		if (state_q == ST_SQUARE) begin
			sqx_q <= (2*GW-1)'((2*GW)'(gx_q) * (2*GW)'(gx_q));
			sqy_q <= (2*GW-1)'((2*GW)'(gy_q) * (2*GW)'(gy_q));
		end
	end

	// 3x3 window, newest column in the last three taps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (mem_we) begin
			for (int i = 0; i < 6; i++) win_q[i] <= win_q[i+3];
			win_q[6] <= top_v;
			win_q[7] <= mid_v;
			win_q[8] <= bot_v;
		end
	end

	// Line stores: read the column, then write it back shifted down one row.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			up_rd_q  <= upper_mem[col_q];
			mid_rd_q <= middle_mem[col_q];
		end
		if (mem_we) begin
			upper_mem[col_q]  <= mid_v;
			middle_mem[col_q] <= bot_v;
		end
	end

	sem_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.value  (sq_sum),
		.busy   (root_busy),
		.done   (root_done),
		.root   (root_val)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_mag_q <= root_val;
			out_fe_q  <= fe_q;
		end
	end

	assign empty     = !out_valid_q;
	assign magnitude = out_mag_q;
	assign frame_end = out_fe_q;

	// The window's column position never reaches the effective width.
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < w_eff || $past(geom.restart) || geom.restart)
		else $error("column position beyond frame width");

	// A root computation is never restarted while one is running.
	a_root_free: assert property (@(posedge clk) disable iff (!arst_n)
		root_start |-> !root_busy)
		else $error("square root started while busy");

	// A waiting result that is not taken is kept.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(out_mag_q))
		else $error("pending result lost");

endmodule
`default_nettype wire

// ===== design/sobel_edge_magnitude_core.sv =====
// Top level of the Sobel edge magnitude core: configuration registers and the front/back parts.
// Pixels go in as RGB in raster order and leave as Sobel gradient magnitudes of their
// luminance, W+1 pixels behind the input; drain items flush the owed results and the last
// result of a frame has frame_end set. The front part takes one item per cycle, while the
// four-entry queue behind it is not full. The back part works one item at a time: a pixel
// without a result passes the line store read and the window update, an item with a result
// then squares, sums and runs the 19-step bit-serial square root, and a drain whose first
// step gives no result takes a second read and update step. A result left waiting in the
// single result register holds the back part until it is popped. Configure only while idle;
// either register write restarts the frame position.
`default_nettype none
module sobel_edge_magnitude_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic                          operation,
	input  wire logic [15:0]                   red,
	input  wire logic [15:0]                   green,
	input  wire logic [15:0]                   blue,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [sem_pkg::MAG_W-1:0]          magnitude,
	output logic                               frame_end,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [sem_pkg::CIDX_W-1:0]    cfg_index,
	input  wire logic [sem_pkg::CDATA_W-1:0]   cfg_data
);

	logic [sem_pkg::WREG_W-1:0] width_q;
	logic [sem_pkg::HREG_W-1:0] height_q;
	logic                       cfg_hit;
	sem_pkg::geom_t             geom;
	sem_pkg::qent_t             fq_data, qb_data;
	logic                       fq_push, q_full, q_empty, q_pop;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == sem_pkg::REG_WIDTH
		|| cfg_index == sem_pkg::REG_HEIGHT);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sem_pkg::WREG_W'(640);
			height_q <= sem_pkg::HREG_W'(480);
		end else if (cfg_valid) begin
			if (cfg_index == sem_pkg::REG_WIDTH) width_q <= cfg_data[sem_pkg::WREG_W-1:0];
			else if (cfg_index == sem_pkg::REG_HEIGHT) height_q <= cfg_data;
		end
	end

	assign geom = '{width: width_q, height: height_q, restart: cfg_hit};

	sem_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.q_full    (q_full),
		.q_push    (fq_push),
		.q_data    (fq_data)
	);

	sem_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data (fq_data),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (qb_data),
		.empty   (q_empty)
	);

	sem_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.q_data    (qb_data),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.magnitude (magnitude),
		.frame_end (frame_end)
	);

endmodule
`default_nettype wire
